### rtl/core/mi3_pkg.sv
// Shared widths, types and cofactor index tables for the 3x3 inverse core.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int DW  = 32;            // element width
  localparam int FB  = 16;            // fraction bits
  localparam int NE  = 9;             // elements per matrix
  localparam int PW  = 2 * DW;        // element product
  localparam int AW  = 2 * DW + 1;    // adjugate entry
  localparam int DTW = 3 * DW + 3;    // determinant
  localparam int QB  = 2 * FB + 1;    // quotient bits, one below the LSB for rounding
  localparam int MW  = ((QB > DW) ? QB : DW) + 1;

  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = QB + 2;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (DW - 1);
  localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);

  // adj[k] = a[PA]*a[PB] - a[MA]*a[MB], row-major element numbering
  localparam int ADJ_PA [NE] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int ADJ_PB [NE] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int ADJ_MA [NE] = '{7, 1, 2, 3, 6, 0, 6, 0, 1};
  localparam int ADJ_MB [NE] = '{5, 8, 4, 8, 2, 5, 4, 7, 3};

  typedef logic [NE-1:0][DW-1:0] mat_t;
  typedef logic [QB:0][DTW-1:0] dline_t;

  typedef struct packed {
    logic [NE-1:0][AW-1:0] n_mag;
    logic [NE-1:0]         neg;
    logic [DTW-1:0]        d_mag;
    logic                  sing;
  } front_t;

endpackage

### rtl/core/matrix3x3_inverse_core.sv
// Top level: front pipeline, nine divider lanes, merge and output skid stage.
`timescale 1ns / 1ps
// 3x3 matrix inverse, Q16.16 in and out. One matrix is accepted per cycle while the skid
// register is empty, and one inverse leaves per cycle while m_tready is high. The front
// registers products, adjugate and determinant; each divider lane has one stage per
// quotient bit of a 33-bit restoring division, plus entry and rounding; an output
// register follows. Nine lanes divide the nine adjugate entries by the shared
// determinant in parallel. A zero determinant raises singular and zeroes the data.
module matrix3x3_inverse_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // a00, a01, a02, a10, a11, a12, a20, a21, a22
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22
  output logic         m_tuser   // singular
);
  import mi3_pkg::*;

  logic                  en;
  logic [PIPE_LAT-1:0]   v;
  front_t                fo;
  dline_t                d_line;
  logic [QB:1][DTW-1:0]  d_pipe;
  logic [LANE_LAT-1:0]   sing_st;
  logic [NE-1:0][DW-1:0] res_all;
  logic [NE*DW-1:0]      merged;
  logic                  skid_valid;
  logic [NE*DW-1:0]      skid_data;
  logic                  skid_user;

  assign en       = !skid_valid;
  assign s_tready = !skid_valid;

  mi3_front u_front (
    .clk (clk),
    .en  (en),
    .mat (mat_t'(s_tdata)),
    .fo  (fo)
  );

  assign d_line = {d_pipe, fo.d_mag};

  always_ff @(posedge clk) begin
    if (en) begin
      d_pipe  <= d_line[QB-1:0];
      sing_st <= {sing_st[LANE_LAT-2:0], fo.sing};
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk    (clk),
      .en     (en),
      .n_mag  (fo.n_mag[k]),
      .neg    (fo.neg[k]),
      .d_line (d_line),
      .res    (res_all[k])
    );
  end

  assign merged = sing_st[LANE_LAT-1] ? '0 : res_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PIPE_LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tdata    <= skid_data;
        m_tuser    <= skid_user;
        skid_valid <= 1'b0;
      end
    end else if (v[PIPE_LAT-1]) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= merged;
        m_tuser  <= sing_st[LANE_LAT-1];
      end else begin
        // hold the result aside while the output stalls
        skid_valid <= 1'b1;
        skid_data  <= merged;
        skid_user  <= sing_st[LANE_LAT-1];
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/core/mi3_front.sv
// Front pipeline: element products, adjugate, determinant, magnitudes and signs.
`timescale 1ns / 1ps
module mi3_front (
  input  logic            clk,
  input  logic            en,
  input  mi3_pkg::mat_t   mat,
  output mi3_pkg::front_t fo
);
  import mi3_pkg::*;

  logic signed [PW-1:0]  p_pos [NE];
  logic signed [PW-1:0]  p_neg [NE];
  logic [2:0][DW-1:0]    a1r;
  logic [2:0][DW-1:0]    a2r;
  logic signed [AW-1:0]  adj2r [NE];
  logic signed [AW-1:0]  adj3r [NE];
  logic signed [AW-1:0]  adj4r [NE];
  logic signed [AW-1:0]  adj5r [NE];
  logic signed [AW-1:0]  lo_p [3];
  logic signed [AW-1:0]  hi_p [3];
  logic signed [DTW-1:0] t [3];
  logic signed [DTW-1:0] det;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        p_pos[k] <= $signed(mat[ADJ_PA[k]]) * $signed(mat[ADJ_PB[k]]);
        p_neg[k] <= $signed(mat[ADJ_MA[k]]) * $signed(mat[ADJ_MB[k]]);
        adj2r[k] <= AW'(p_pos[k]) - AW'(p_neg[k]);
        adj3r[k] <= adj2r[k];
        adj4r[k] <= adj3r[k];
        adj5r[k] <= adj4r[k];
      end
      for (int j = 0; j < 3; j++) begin
        a1r[j] <= mat[j];
        a2r[j] <= a1r[j];
        // split the adjugate entry into an unsigned low word and a signed high part
        lo_p[j] <= $signed(a2r[j]) * $signed({1'b0, adj2r[3*j][DW-1:0]});
        hi_p[j] <= $signed(a2r[j]) * $signed(adj2r[3*j][AW-1:DW]);
        t[j]    <= (DTW'(hi_p[j]) <<< DW) + DTW'(lo_p[j]);
      end
      det <= t[0] + t[1] + t[2];
      fo.d_mag <= det[DTW-1] ? DTW'(-det) : DTW'(det);
      fo.sing  <= (det == '0);
      for (int k = 0; k < NE; k++) begin
        fo.n_mag[k] <= adj5r[k][AW-1] ? AW'(-adj5r[k]) : AW'(adj5r[k]);
        fo.neg[k]   <= adj5r[k][AW-1] ^ det[DTW-1];
      end
    end
  end

endmodule

### rtl/core/mi3_div_lane.sv
// One divider lane: restoring division of an adjugate magnitude, round and saturate.
`timescale 1ns / 1ps
module mi3_div_lane (
  input  logic                  clk,
  input  logic                  en,
  input  logic [mi3_pkg::AW-1:0] n_mag,
  input  logic                  neg,
  input  mi3_pkg::dline_t       d_line,
  output logic [mi3_pkg::DW-1:0] res
);
  import mi3_pkg::*;

  logic [DTW-1:0] r_st [QB];
  logic [QB-1:0]  q_st [QB+1];
  logic           neg_st [QB+1];
  logic           over_st [QB+1];
  logic [MW-1:0]  m;
  logic [MW-1:0]  lim;
  logic [MW-1:0]  mag;

  // a quotient of one or more saturates; otherwise start with remainder below divisor
  always_ff @(posedge clk) begin
    if (en) begin
      over_st[0] <= DTW'(n_mag) >= d_line[0];
      r_st[0]    <= (DTW'(n_mag) >= d_line[0]) ? '0 : DTW'(n_mag);
      neg_st[0]  <= neg;
      q_st[0]    <= '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DTW:0] r2;
    logic [DTW:0] df;
    logic         ge;
    assign r2 = {r_st[i-1], 1'b0};
    assign ge = r2 >= {1'b0, d_line[i]};
    assign df = r2 - {1'b0, d_line[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        q_st[i]    <= {q_st[i-1][QB-2:0], ge};
        neg_st[i]  <= neg_st[i-1];
        over_st[i] <= over_st[i-1];
      end
    end
    if (i < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_st[i] <= ge ? df[DTW-1:0] : r2[DTW-1:0];
        end
      end
    end
  end

  // round half away from zero on the magnitude, then clamp
  always_comb begin
    m   = MW'(q_st[QB][QB-1:1]) + MW'(q_st[QB][0]);
    lim = neg_st[QB] ? LIM_NEG : LIM_POS;
    mag = (over_st[QB] || (m > lim)) ? lim : m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= neg_st[QB] ? DW'(~mag + MW'(1)) : DW'(mag);
    end
  end

endmodule

### rtl/core/mi3_checker.sv
// Port checker for the 3x3 inverse core and its bind.
`timescale 1ns / 1ps
module mi3_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [287:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [287:0] m_tdata,
  input logic         m_tuser
);

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input throttled without an output stall");

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (.*);

### bench/matrix3x3_inverse_core_tb.sv
// Testbench for the 3x3 Q16.16 matrix inverse core: random and directed matrices.
`timescale 1ns / 1ps
module matrix3x3_inverse_core_tb;
  import mi3_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [NE-1:0][DW-1:0] inv;
    logic                  singular;
  } inverse_t;

  // Exact inverse: adjugate over determinant, rounded half away from zero, saturated.
  function automatic inverse_t predict_inverse(input logic [NE-1:0][DW-1:0] m);
    inverse_t r;
    logic signed [127:0] a [NE];
    logic signed [127:0] adj [NE];
    logic signed [127:0] det;
    logic signed [255:0] num, den, q2, q;
    logic neg;
    for (int i = 0; i < NE; i++) a[i] = $signed(m[i]);
    adj[0] = a[4] * a[8] - a[7] * a[5];
    adj[1] = -(a[1] * a[8] - a[7] * a[2]);
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = -(a[3] * a[8] - a[6] * a[5]);
    adj[4] = a[0] * a[8] - a[6] * a[2];
    adj[5] = -(a[0] * a[5] - a[3] * a[2]);
    adj[6] = a[3] * a[7] - a[6] * a[4];
    adj[7] = -(a[0] * a[7] - a[6] * a[1]);
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    r.singular = (det == 0);
    for (int i = 0; i < NE; i++) begin
      if (r.singular) begin
        r.inv[i] = '0;
      end else begin
        neg = (adj[i] < 0) != (det < 0);
        num = (adj[i] < 0) ? -256'(adj[i]) : 256'(adj[i]);
        den = (det < 0) ? -256'(det) : 256'(det);
        q2 = (num <<< (2 * FB + 1)) / den;
        q = (q2 >>> 1) + (q2 & 1);
        if (neg) begin
          if (q > 256'(64'h8000_0000)) q = 256'(64'h8000_0000);
          r.inv[i] = DW'(-q);
        end else begin
          if (q > 256'(64'h7FFF_FFFF)) q = 256'(64'h7FFF_FFFF);
          r.inv[i] = DW'(q);
        end
      end
    end
    return r;
  endfunction

  int errors = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  class inverse_scoreboard;
    inverse_t pending [$];
    function void note_request(logic [NE-1:0][DW-1:0] m);
      pending.push_back(predict_inverse(m));
    endfunction
    task check_result(logic [NE-1:0][DW-1:0] inv, logic singular);
      inverse_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (singular !== e.singular)
        report($sformatf("singular got %0b want %0b", singular, e.singular));
      for (int i = 0; i < NE; i++)
        if (inv[i] !== e.inv[i])
          report($sformatf("inv%0d%0d got %h want %h", i / 3, i % 3, inv[i], e.inv[i]));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [287:0] s_tdata = '0;
  logic s_tready, m_tvalid, m_tuser;
  logic [287:0] m_tdata;
  bit quiet = 0;
  int idle_cnt = 0;
  inverse_scoreboard sb = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  matrix3x3_inverse_core u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Result side: check accepted results, stall in random bursts.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  initial begin
    int n;
    wait (!rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        m_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
    end
  end

  // Watchdog: count cycles with no request or result moving.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cnt <= 0;
    end else if (!rst) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("matrix3x3_inverse_core_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [DW-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4) << FB;
      3: return 32'(int'($urandom_range(0, 64)) - 32);
      4: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_matrix(input logic [NE-1:0][DW-1:0] m, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= m;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(m);
  endtask

  task automatic send_diag(input logic [DW-1:0] d0, d1, d2);
    logic [NE-1:0][DW-1:0] m;
    m = '0;
    m[0] = d0; m[4] = d1; m[8] = d2;
    send_matrix(m, 1);
  endtask

  initial begin
    logic [NE-1:0][DW-1:0] m;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: identity, zero, extremes, singular, rounding and saturation.
    send_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_diag(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    send_diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_diag(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
    send_diag(32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
    send_diag(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000);
    send_matrix('0, 1);
    send_matrix({NE{32'hFFFF_FFFF}}, 1);
    send_matrix({NE{32'h7FFF_FFFF}}, 1);
    send_matrix({NE{32'h8000_0000}}, 1);
    for (int i = 0; i < NE; i++) m[i] = 32'(i + 1) << FB;
    send_matrix(m, 1);
    m[8] = 32'h000A_0000;
    send_matrix(m, 1);
    send_matrix({NE{32'hAAAA_5555}}, 1);
    send_matrix({NE{32'h5555_AAAA}}, 1);
    // Hold until the pipeline drains.
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    for (int k = 0; k < 1750; k++) begin
      if (k == 1500) quiet = 1;
      for (int i = 0; i < NE; i++) m[i] = rand_entry();
      // Make some rows dependent to reach singular matrices.
      if ($urandom_range(0, 9) == 0) begin
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end
      send_matrix(m, !quiet);
    end
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("matrix3x3_inverse_core_tb: PASS");
    end else begin
      $display("matrix3x3_inverse_core_tb: FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_div_lane.sv
rtl/core/matrix3x3_inverse_core.sv
rtl/core/mi3_checker.sv
bench/matrix3x3_inverse_core_tb.sv
